/* rtl/assert_macros.svh */
// Assertion macros shared by the rotation core RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define IRBL_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define IRBL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define IRBL_ASSERT(lbl, clk, rstn, prop, msg)
`define IRBL_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

/* rtl/irbl_pkg.sv */
// Shared types and constants of the rotation core.
// No dependencies.
package irbl_pkg;

  localparam int FRAC_BITS = 14;
  localparam int COORD_W   = 14;
  localparam int PROD_W    = 30;
  localparam int SUM_W     = 31;
  localparam int CNT_W     = 13;
  localparam int PIX_W     = 24;

  localparam int DEF_MAX_ROWS    = 1024;
  localparam int DEF_MAX_COLS    = 1024;
  localparam int DEF_WEIGHT_BITS = 8;

  typedef enum logic [2:0] {
    REG_COS      = 3'd0,
    REG_SIN      = 3'd1,
    REG_OFFSET_R = 3'd2,
    REG_OFFSET_C = 3'd3,
    REG_ROWS     = 3'd4,
    REG_COLS     = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic vld;
    logic query;
    logic wen;
    logic in_img;
    logic rpar;
    logic cpar;
    logic rclamp;
    logic cclamp;
  } ctrl_t;

endpackage

/* rtl/image_rotate_backward_bilinear_core.sv */
// Rotation core top level: register port, transform, frame store, blend.
// Depends on irbl_pkg, irbl_xform, irbl_fstore, irbl_blend.
//
// One request per clock, always: busy_o stays low. A write request inside the
// store stores one source pixel; a query request returns exactly one result,
// on res_valid_o for one cycle, after the offset, rotate products, sums,
// bounds/index, store read, weights and blend registers, in request order.
// Writes and queries may be mixed freely; a query sees every earlier write.
// The frame store is four parity banks of a single read/write port each,
// which lets all four neighbors be read in the same cycle. Entries never
// written read as unknown. Results cannot be held off. Registers are to be
// written only while no request is in flight; the block does not enforce it.
`include "assert_macros.svh"
module image_rotate_backward_bilinear_core import irbl_pkg::*; #(
  parameter int MAX_ROWS    = DEF_MAX_ROWS,
  parameter int MAX_COLS    = DEF_MAX_COLS,
  parameter int WEIGHT_BITS = DEF_WEIGHT_BITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        req_type_i,
  input  logic [10:0] row_i,
  input  logic [10:0] col_i,
  input  logic [7:0]  blue_in_i,
  input  logic [7:0]  green_in_i,
  input  logic [7:0]  red_in_i,
  output logic        res_valid_o,
  output logic [7:0]  blue_out_o,
  output logic [7:0]  green_out_o,
  output logic [7:0]  red_out_o,
  output logic        inside_res_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IDX_R = $clog2(MAX_ROWS);
  localparam int IDX_C = $clog2(MAX_COLS);

  logic signed [15:0] cos_q, sin_q;
  logic signed [12:0] off_r_q, off_c_q;
  logic [10:0] rows_q, cols_q;
  reg_idx_e reg_idx;

  assign reg_idx = reg_idx_e'(paddr[4:2]);
  assign pready  = 1'b1;
  assign busy_o  = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cos_q   <= 16'sd16384;
      sin_q   <= '0;
      off_r_q <= '0;
      off_c_q <= '0;
      rows_q  <= 11'd1024;
      cols_q  <= 11'd1024;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_COS:      cos_q   <= pwdata[15:0];
        REG_SIN:      sin_q   <= pwdata[15:0];
        REG_OFFSET_R: off_r_q <= pwdata[12:0];
        REG_OFFSET_C: off_c_q <= pwdata[12:0];
        REG_ROWS:     rows_q  <= pwdata[10:0];
        REG_COLS:     cols_q  <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_COS:      prdata = 32'(unsigned'(cos_q));
      REG_SIN:      prdata = 32'(unsigned'(sin_q));
      REG_OFFSET_R: prdata = 32'(unsigned'(off_r_q));
      REG_OFFSET_C: prdata = 32'(unsigned'(off_c_q));
      REG_ROWS:     prdata = 32'(rows_q);
      REG_COLS:     prdata = 32'(cols_q);
      default:      prdata = '0;
    endcase
  end

  ctrl_t x_ctrl, f_ctrl;
  logic [1:0][IDX_R-2:0] x_rh;
  logic [1:0][IDX_C-2:0] x_ch;
  logic [WEIGHT_BITS-1:0] x_wr, x_wc, f_wr, f_wc;
  logic [PIX_W-1:0] x_pix;
  logic [1:0][1:0][PIX_W-1:0] f_rd;

  irbl_xform #(
    .MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS), .WEIGHT_BITS(WEIGHT_BITS)
  ) u_xform (
    .clk_i, .rst_ni,
    .vld_i(start_i), .req_type_i, .row_i, .col_i,
    .pix_i({red_in_i, green_in_i, blue_in_i}),
    .cos_i(cos_q), .sin_i(sin_q), .off_r_i(off_r_q), .off_c_i(off_c_q),
    .src_rows_i(rows_q), .src_cols_i(cols_q),
    .ctrl_o(x_ctrl), .rh_o(x_rh), .ch_o(x_ch), .wr_o(x_wr), .wc_o(x_wc), .pix_o(x_pix)
  );

  irbl_fstore #(
    .MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS), .WEIGHT_BITS(WEIGHT_BITS)
  ) u_fstore (
    .clk_i, .rst_ni,
    .ctrl_i(x_ctrl), .rh_i(x_rh), .ch_i(x_ch), .wr_i(x_wr), .wc_i(x_wc), .pix_i(x_pix),
    .ctrl_o(f_ctrl), .wr_o(f_wr), .wc_o(f_wc), .rd_o(f_rd)
  );

  irbl_blend #(
    .WEIGHT_BITS(WEIGHT_BITS)
  ) u_blend (
    .clk_i, .rst_ni,
    .ctrl_i(f_ctrl), .wr_i(f_wr), .wc_i(f_wc), .rd_i(f_rd),
    .res_valid_o, .blue_out_o, .green_out_o, .red_out_o, .inside_res_o
  );

  `IRBL_ASSERT(a_res_from_query, clk_i, rst_ni, res_valid_o |-> $past(start_i && req_type_i, 7), "result without a query request")
  `IRBL_ASSERT(a_outside_black, clk_i, rst_ni, (res_valid_o && !inside_res_o) |-> (blue_out_o == 8'd0 && green_out_o == 8'd0 && red_out_o == 8'd0), "outside result not black")

endmodule

/* rtl/irbl_xform.sv */
// Coordinate transform pipeline: offset add, rotation products, sums,
// bounds check and neighbor index split. Depends on irbl_pkg.
`include "assert_macros.svh"
module irbl_xform import irbl_pkg::*; #(
  parameter int MAX_ROWS    = DEF_MAX_ROWS,
  parameter int MAX_COLS    = DEF_MAX_COLS,
  parameter int WEIGHT_BITS = DEF_WEIGHT_BITS,
  localparam int IDX_R      = $clog2(MAX_ROWS),
  localparam int IDX_C      = $clog2(MAX_COLS)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              vld_i,
  input  logic                              req_type_i,
  input  logic [10:0]                       row_i,
  input  logic [10:0]                       col_i,
  input  logic [PIX_W-1:0]                  pix_i,
  input  logic signed [15:0]                cos_i,
  input  logic signed [15:0]                sin_i,
  input  logic signed [12:0]                off_r_i,
  input  logic signed [12:0]                off_c_i,
  input  logic [10:0]                       src_rows_i,
  input  logic [10:0]                       src_cols_i,
  output ctrl_t                             ctrl_o,
  output logic [1:0][IDX_R-2:0]             rh_o,
  output logic [1:0][IDX_C-2:0]             ch_o,
  output logic [WEIGHT_BITS-1:0]            wr_o,
  output logic [WEIGHT_BITS-1:0]            wc_o,
  output logic [PIX_W-1:0]                  pix_o
);

  logic [CNT_W-1:0] rows_eff, cols_eff;
  assign rows_eff = (CNT_W'(src_rows_i) < CNT_W'(MAX_ROWS)) ? CNT_W'(src_rows_i)
                                                           : CNT_W'(MAX_ROWS);
  assign cols_eff = (CNT_W'(src_cols_i) < CNT_W'(MAX_COLS)) ? CNT_W'(src_cols_i)
                                                           : CNT_W'(MAX_COLS);

  // stage 0: offsets
  logic s0_vld_q, s0_qry_q;
  logic signed [COORD_W-1:0] s0_r_q, s0_c_q;
  logic [10:0] s0_row_q, s0_col_q;
  logic [PIX_W-1:0] s0_pix_q;
  // stage 1: products
  logic s1_vld_q, s1_qry_q;
  logic signed [PROD_W-1:0] s1_cr_q, s1_sc_q, s1_sr_q, s1_cc_q;
  logic [10:0] s1_row_q, s1_col_q;
  logic [PIX_W-1:0] s1_pix_q;
  // stage 2: source point
  logic s2_vld_q, s2_qry_q;
  logic signed [SUM_W-1:0] s2_sr_q, s2_sc_q;
  logic [10:0] s2_row_q, s2_col_q;
  logic [PIX_W-1:0] s2_pix_q;
  // stage 3: indices
  ctrl_t ctrl_d, ctrl_q;
  logic [1:0][IDX_R-2:0] rh_d, rh_q;
  logic [1:0][IDX_C-2:0] ch_d, ch_q;
  logic [WEIGHT_BITS-1:0] wr_d, wr_q, wc_d, wc_q;
  logic [PIX_W-1:0] pix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      ctrl_q   <= '0;
    end else begin
      s0_vld_q <= vld_i;
      s1_vld_q <= s0_vld_q;
      s2_vld_q <= s1_vld_q;
      ctrl_q   <= ctrl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s0_qry_q <= req_type_i;
    s0_r_q   <= $signed({3'b000, row_i}) + $signed({off_r_i[12], off_r_i});
    s0_c_q   <= $signed({3'b000, col_i}) + $signed({off_c_i[12], off_c_i});
    s0_row_q <= row_i;
    s0_col_q <= col_i;
    s0_pix_q <= pix_i;

    s1_qry_q <= s0_qry_q;
    s1_cr_q  <= cos_i * s0_r_q;
    s1_sc_q  <= sin_i * s0_c_q;
    s1_sr_q  <= sin_i * s0_r_q;
    s1_cc_q  <= cos_i * s0_c_q;
    s1_row_q <= s0_row_q;
    s1_col_q <= s0_col_q;
    s1_pix_q <= s0_pix_q;

    s2_qry_q <= s1_qry_q;
    s2_sr_q  <= $signed({s1_cr_q[PROD_W-1], s1_cr_q}) - $signed({s1_sc_q[PROD_W-1], s1_sc_q});
    s2_sc_q  <= $signed({s1_sr_q[PROD_W-1], s1_sr_q}) + $signed({s1_cc_q[PROD_W-1], s1_cc_q});
    s2_row_q <= s1_row_q;
    s2_col_q <= s1_col_q;
    s2_pix_q <= s1_pix_q;

    rh_q  <= rh_d;
    ch_q  <= ch_d;
    wr_q  <= wr_d;
    wc_q  <= wc_d;
    pix_q <= s2_pix_q;
  end

  logic [SUM_W-FRAC_BITS-1:0] sr_int, sc_int;
  logic [CNT_W-1:0] row_ext, col_ext;
  logic [IDX_R-1:0] ir, idx_r;
  logic [IDX_C-1:0] ic, idx_c;
  logic [IDX_R:0] idx_r_p1;
  logic [IDX_C:0] idx_c_p1;
  logic in_img, wen, rcl, ccl, use_idx;

  assign sr_int  = s2_sr_q[SUM_W-1:FRAC_BITS];
  assign sc_int  = s2_sc_q[SUM_W-1:FRAC_BITS];
  assign in_img  = !s2_sr_q[SUM_W-1] && !s2_sc_q[SUM_W-1]
                   && (sr_int < (SUM_W-FRAC_BITS)'(rows_eff))
                   && (sc_int < (SUM_W-FRAC_BITS)'(cols_eff));
  assign ir      = s2_sr_q[FRAC_BITS +: IDX_R];
  assign ic      = s2_sc_q[FRAC_BITS +: IDX_C];
  assign row_ext = CNT_W'(s2_row_q);
  assign col_ext = CNT_W'(s2_col_q);
  assign wen     = !s2_qry_q && (row_ext < CNT_W'(MAX_ROWS)) && (col_ext < CNT_W'(MAX_COLS));
  assign use_idx = s2_qry_q ? in_img : wen;
  assign idx_r   = !use_idx ? '0 : (s2_qry_q ? ir : row_ext[IDX_R-1:0]);
  assign idx_c   = !use_idx ? '0 : (s2_qry_q ? ic : col_ext[IDX_C-1:0]);
  assign rcl     = s2_qry_q && in_img && ((CNT_W'(ir) + CNT_W'(1)) == rows_eff);
  assign ccl     = s2_qry_q && in_img && ((CNT_W'(ic) + CNT_W'(1)) == cols_eff);
  assign idx_r_p1 = {1'b0, idx_r} + (IDX_R+1)'(1);
  assign idx_c_p1 = {1'b0, idx_c} + (IDX_C+1)'(1);
  assign wr_d    = s2_sr_q[FRAC_BITS-1 -: WEIGHT_BITS];
  assign wc_d    = s2_sc_q[FRAC_BITS-1 -: WEIGHT_BITS];

  for (genvar g = 0; g < 2; g++) begin : g_half
    assign rh_d[g] = (idx_r[0] == 1'(g) || rcl) ? idx_r[IDX_R-1:1] : idx_r_p1[IDX_R-1:1];
    assign ch_d[g] = (idx_c[0] == 1'(g) || ccl) ? idx_c[IDX_C-1:1] : idx_c_p1[IDX_C-1:1];
  end

  always_comb begin
    ctrl_d        = '0;
    ctrl_d.vld    = s2_vld_q;
    ctrl_d.query  = s2_qry_q;
    ctrl_d.wen    = s2_vld_q && wen;
    ctrl_d.in_img = in_img;
    ctrl_d.rpar   = idx_r[0];
    ctrl_d.cpar   = idx_c[0];
    ctrl_d.rclamp = rcl;
    ctrl_d.cclamp = ccl;
  end

  assign ctrl_o = ctrl_q;
  assign rh_o   = rh_q;
  assign ch_o   = ch_q;
  assign wr_o   = wr_q;
  assign wc_o   = wc_q;
  assign pix_o  = pix_q;

  `IRBL_ASSERT(a_inside_idx, clk_i, rst_ni, (s2_vld_q && s2_qry_q && in_img) |-> ((CNT_W'(ir) < rows_eff) && (CNT_W'(ic) < cols_eff)), "inside point indexes past the image")

endmodule

/* rtl/irbl_fstore.sv */
// Frame store split in four banks by row and column parity, so the four
// bilinear neighbors read in the same cycle. Depends on irbl_pkg.
`include "assert_macros.svh"
module irbl_fstore import irbl_pkg::*; #(
  parameter int MAX_ROWS    = DEF_MAX_ROWS,
  parameter int MAX_COLS    = DEF_MAX_COLS,
  parameter int WEIGHT_BITS = DEF_WEIGHT_BITS,
  localparam int IDX_R      = $clog2(MAX_ROWS),
  localparam int IDX_C      = $clog2(MAX_COLS)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ctrl_t                        ctrl_i,
  input  logic [1:0][IDX_R-2:0]        rh_i,
  input  logic [1:0][IDX_C-2:0]        ch_i,
  input  logic [WEIGHT_BITS-1:0]       wr_i,
  input  logic [WEIGHT_BITS-1:0]       wc_i,
  input  logic [PIX_W-1:0]             pix_i,
  output ctrl_t                        ctrl_o,
  output logic [WEIGHT_BITS-1:0]       wr_o,
  output logic [WEIGHT_BITS-1:0]       wc_o,
  output logic [1:0][1:0][PIX_W-1:0]   rd_o
);

  localparam int HALF_R = (MAX_ROWS + 1) / 2;
  localparam int HALF_C = (MAX_COLS + 1) / 2;
  localparam int DEPTH  = HALF_R * HALF_C;
  localparam int AW     = $clog2(DEPTH);
  localparam logic [AW-1:0] HALF_C_A = AW'(HALF_C);

  ctrl_t ctrl_q;
  logic [WEIGHT_BITS-1:0] wr_q, wc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else begin
      ctrl_q <= ctrl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    wr_q <= wr_i;
    wc_q <= wc_i;
  end

  for (genvar q = 0; q < 2; q++) begin : g_rbank
    for (genvar s = 0; s < 2; s++) begin : g_cbank
      logic [PIX_W-1:0] mem [DEPTH];
      logic [AW-1:0] addr;
      logic [PIX_W-1:0] rd_q;
      logic we;

      assign addr = AW'(rh_i[q]) * HALF_C_A + AW'(ch_i[s]);
      assign we   = ctrl_i.wen && (ctrl_i.rpar == 1'(q)) && (ctrl_i.cpar == 1'(s));

      always_ff @(posedge clk_i) begin
        if (we) begin
          mem[addr] <= pix_i;
        end
        rd_q <= mem[addr];
      end

      assign rd_o[q][s] = rd_q;
    end
  end

  assign ctrl_o = ctrl_q;
  assign wr_o   = wr_q;
  assign wc_o   = wc_q;

  `IRBL_ASSERT_ALWAYS(a_wen_write_only, clk_i, ctrl_i.wen |-> (ctrl_i.vld && !ctrl_i.query), "store write from a query request")

endmodule

/* rtl/irbl_blend.sv */
// Bilinear blend: neighbor selection with edge clamp, weights, then the
// per-channel weighted sum with rounding. Depends on irbl_pkg.
module irbl_blend import irbl_pkg::*; #(
  parameter int WEIGHT_BITS = DEF_WEIGHT_BITS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ctrl_t                       ctrl_i,
  input  logic [WEIGHT_BITS-1:0]      wr_i,
  input  logic [WEIGHT_BITS-1:0]      wc_i,
  input  logic [1:0][1:0][PIX_W-1:0]  rd_i,
  output logic                        res_valid_o,
  output logic [7:0]                  blue_out_o,
  output logic [7:0]                  green_out_o,
  output logic [7:0]                  red_out_o,
  output logic                        inside_res_o
);

  localparam int WW    = 2 * WEIGHT_BITS + 1;
  localparam int ACC_W = WW + 10;
  localparam logic [WEIGHT_BITS:0] ONE = {1'b1, {WEIGHT_BITS{1'b0}}};
  localparam logic [ACC_W-1:0] HALF = ACC_W'(1) << (2 * WEIGHT_BITS - 1);

  logic [PIX_W-1:0] p00, p01, p10, p11;
  logic [WEIGHT_BITS:0] omr, omc;

  assign p00 = rd_i[ctrl_i.rpar][ctrl_i.cpar];
  assign p01 = ctrl_i.cclamp ? p00 : rd_i[ctrl_i.rpar][!ctrl_i.cpar];
  assign p10 = ctrl_i.rclamp ? p00 : rd_i[!ctrl_i.rpar][ctrl_i.cpar];
  assign p11 = ctrl_i.rclamp ? p01 : (ctrl_i.cclamp ? p10 : rd_i[!ctrl_i.rpar][!ctrl_i.cpar]);
  assign omr = ONE - {1'b0, wr_i};
  assign omc = ONE - {1'b0, wc_i};

  logic w_vld_q, w_in_q;
  logic [WW-1:0] w00_q, w01_q, w10_q, w11_q;
  logic [PIX_W-1:0] p00_q, p01_q, p10_q, p11_q;
  logic vld_q, in_q;
  logic [PIX_W-1:0] pix_q;
  logic [2:0][ACC_W-1:0] acc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_vld_q <= 1'b0;
      vld_q   <= 1'b0;
    end else begin
      w_vld_q <= ctrl_i.vld && ctrl_i.query;
      vld_q   <= w_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    w_in_q <= ctrl_i.in_img;
    w00_q  <= WW'(omr) * WW'(omc);
    w01_q  <= WW'(omr) * WW'(wc_i);
    w10_q  <= WW'(wr_i) * WW'(omc);
    w11_q  <= WW'(wr_i) * WW'(wc_i);
    p00_q  <= p00;
    p01_q  <= p01;
    p10_q  <= p10;
    p11_q  <= p11;
    in_q   <= w_in_q;
  end

  for (genvar ch = 0; ch < 3; ch++) begin : g_chan
    assign acc[ch] = ACC_W'(w00_q) * ACC_W'(p00_q[8*ch +: 8])
                   + ACC_W'(w01_q) * ACC_W'(p01_q[8*ch +: 8])
                   + ACC_W'(w10_q) * ACC_W'(p10_q[8*ch +: 8])
                   + ACC_W'(w11_q) * ACC_W'(p11_q[8*ch +: 8]) + HALF;
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      pix_q[8*k +: 8] <= w_in_q ? acc[k][2*WEIGHT_BITS +: 8] : 8'd0;
    end
  end

  assign res_valid_o  = vld_q;
  assign blue_out_o   = pix_q[7:0];
  assign green_out_o  = pix_q[15:8];
  assign red_out_o    = pix_q[23:16];
  assign inside_res_o = in_q;

endmodule

/* tb/sv/tb.sv */
// Self-checking testbench for image_rotate_backward_bilinear_core.
// Holds its own rotation/bilinear predictor; drives requests and APB writes.
// Depends on irbl_pkg and the core RTL.
`timescale 1ns / 1ps

typedef struct {
  bit        query;
  bit [10:0] row;
  bit [10:0] col;
  bit [23:0] bgr;
} rot_request_t;

typedef struct packed {
  bit [7:0] blue;
  bit [7:0] green;
  bit [7:0] red;
  bit       in_img;
} rot_pixel_t;

class rot_scoreboard;
  bit [23:0]  pixels[int];
  longint     cos_q, sin_q, off_r, off_c;
  int         src_rows, src_cols;
  rot_pixel_t expected_q[$];
  int         errors;

  function new();
    cos_q = 16384; sin_q = 0; off_r = 0; off_c = 0;
    src_rows = 1024; src_cols = 1024; errors = 0;
  endfunction

  function void set_reg(irbl_pkg::reg_idx_e idx, bit [31:0] v);
    case (idx)
      irbl_pkg::REG_COS:      cos_q = longint'($signed(v[15:0]));
      irbl_pkg::REG_SIN:      sin_q = longint'($signed(v[15:0]));
      irbl_pkg::REG_OFFSET_R: off_r = longint'($signed(v[12:0]));
      irbl_pkg::REG_OFFSET_C: off_c = longint'($signed(v[12:0]));
      irbl_pkg::REG_ROWS:     src_rows = v[10:0];
      irbl_pkg::REG_COLS:     src_cols = v[10:0];
      default: ;
    endcase
  endfunction

  function int eff_rows();
    return src_rows < 1024 ? src_rows : 1024;
  endfunction

  function int eff_cols();
    return src_cols < 1024 ? src_cols : 1024;
  endfunction

  // Maps an output point back to the source; gives neighbor addresses and weights.
  function bit locate(bit [10:0] row, bit [10:0] col, output int addr[4],
                      output int wr, output int wc);
    longint r, c, sr, sc;
    int rows, cols, ir, ic, ir1, ic1;
    rows = eff_rows();
    cols = eff_cols();
    r = longint'(row) + off_r;
    c = longint'(col) + off_c;
    sr = cos_q * r - sin_q * c;
    sc = sin_q * r + cos_q * c;
    foreach (addr[i]) addr[i] = 0;
    wr = 0; wc = 0;
    if (sr < 0 || sc < 0 || sr >= (longint'(rows) << 14) || sc >= (longint'(cols) << 14))
      return 0;
    ir = int'(sr >> 14);
    ic = int'(sc >> 14);
    wr = int'((sr & 16383) >> 6);
    wc = int'((sc & 16383) >> 6);
    ir1 = (ir + 1 < rows) ? ir + 1 : rows - 1;
    ic1 = (ic + 1 < cols) ? ic + 1 : cols - 1;
    addr[0] = ir * 1024 + ic;
    addr[1] = ir * 1024 + ic1;
    addr[2] = ir1 * 1024 + ic;
    addr[3] = ir1 * 1024 + ic1;
    return 1;
  endfunction

  function void note(rot_request_t req);
    int addr[4];
    int wr, wc;
    longint w[4], acc;
    bit [23:0] p[4];
    rot_pixel_t px;
    if (!req.query) begin
      if (req.row < 1024 && req.col < 1024) pixels[req.row * 1024 + req.col] = req.bgr;
      return;
    end
    px = '{0, 0, 0, 0};
    if (locate(req.row, req.col, addr, wr, wc)) begin
      foreach (p[i]) p[i] = pixels.exists(addr[i]) ? pixels[addr[i]] : 24'h0;
      w[0] = (256 - wr) * (256 - wc);
      w[1] = (256 - wr) * wc;
      w[2] = wr * (256 - wc);
      w[3] = wr * wc;
      for (int ch = 0; ch < 3; ch++) begin
        acc = 32768;
        foreach (p[i]) acc += w[i] * ((p[i] >> (8 * ch)) & 8'hff);
        acc = acc >> 16;
        if (acc > 255) acc = 255;
        case (ch)
          0: px.blue = acc[7:0];
          1: px.green = acc[7:0];
          default: px.red = acc[7:0];
        endcase
      end
      px.in_img = 1;
    end
    expected_q.push_back(px);
  endfunction

  function void check(rot_pixel_t got);
    rot_pixel_t exp_px;
    if (expected_q.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result b=%0d g=%0d r=%0d inside=%0d",
                                 got.blue, got.green, got.red, got.in_img);
      return;
    end
    exp_px = expected_q.pop_front();
    if (got !== exp_px) begin
      errors++;
      if (errors <= 10)
        $display("mismatch: exp b=%0d g=%0d r=%0d in=%0d, got b=%0d g=%0d r=%0d in=%0d",
                 exp_px.blue, exp_px.green, exp_px.red, exp_px.in_img,
                 got.blue, got.green, got.red, got.in_img);
    end
  endfunction
endclass

module tb;
  import irbl_pkg::*;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        start_i = 0;
  logic        busy_o;
  logic        req_type_i = 0;
  logic [10:0] row_i = 0, col_i = 0;
  logic [7:0]  blue_in_i = 0, green_in_i = 0, red_in_i = 0;
  logic        res_valid_o;
  logic [7:0]  blue_out_o, green_out_o, red_out_o;
  logic        inside_res_o;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [4:0]  paddr = 0;
  logic [31:0] pwdata = 0;
  logic [31:0] prdata;
  logic        pready;

  rot_scoreboard sb = new();
  int burst_left = 0;
  int idle_cycles = 0;

  always #1 clk_i = ~clk_i;

  image_rotate_backward_bilinear_core dut (.*);

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o)
        sb.note('{req_type_i, row_i, col_i, {red_in_i, green_in_i, blue_in_i}});
      if (res_valid_o)
        sb.check('{blue_out_o, green_out_o, red_out_o, inside_res_o});
      if ((start_i && !busy_o) || res_valid_o || (psel && penable)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles > 10000) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  task automatic send(bit query, bit [10:0] row, bit [10:0] col, bit [23:0] bgr);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 30);
      repeat (gap) begin
        @(negedge clk_i);
        start_i <= 0;
      end
    end
    @(negedge clk_i);
    start_i <= 1;
    req_type_i <= query;
    row_i <= row;
    col_i <= col;
    {red_in_i, green_in_i, blue_in_i} <= bgr;
    do @(posedge clk_i); while (busy_o);
    burst_left--;
  endtask

  // Writes every neighbor a query would read that is still unknown, then queries.
  task automatic send_query(bit [10:0] row, bit [10:0] col);
    int addr[4];
    int wr, wc;
    if (sb.locate(row, col, addr, wr, wc))
      foreach (addr[i])
        if (!sb.pixels.exists(addr[i]))
          send(0, 11'(addr[i] / 1024), 11'(addr[i] % 1024),
               24'($urandom_range(0, 24'hffffff)));
    send(1, row, col, 24'($urandom_range(0, 24'hffffff)));
  endtask

  task automatic drain();
    @(negedge clk_i);
    start_i <= 0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic apb_write(reg_idx_e idx, bit [31:0] v);
    @(negedge clk_i);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= 5'(idx * 4); pwdata <= v;
    @(negedge clk_i);
    penable <= 1;
    do @(posedge clk_i); while (!pready);
    sb.set_reg(idx, v);
    @(negedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  task automatic configure(int cq, int sq, int orow, int ocol, int rows, int cols);
    drain();
    apb_write(REG_COS, 32'(cq));
    apb_write(REG_SIN, 32'(sq));
    apb_write(REG_OFFSET_R, 32'(orow));
    apb_write(REG_OFFSET_C, 32'(ocol));
    apb_write(REG_ROWS, 32'(rows));
    apb_write(REG_COLS, 32'(cols));
  endtask

  // Aims most queries at points inside the source by rotating a source point forward.
  task automatic random_query();
    longint tr, tc, r, c;
    int rows, cols;
    rows = sb.eff_rows();
    cols = sb.eff_cols();
    if ($urandom_range(0, 9) == 0 || rows == 0 || cols == 0) begin
      send_query(11'($urandom_range(0, 2047)), 11'($urandom_range(0, 2047)));
      return;
    end
    tr = $urandom_range(0, rows * 16384 - 1);
    tc = $urandom_range(0, cols * 16384 - 1);
    r = ((sb.cos_q * tr + sb.sin_q * tc) >>> 28) - sb.off_r + $urandom_range(0, 1);
    c = ((sb.cos_q * tc - sb.sin_q * tr) >>> 28) - sb.off_c + $urandom_range(0, 1);
    if (r < 0 || r > 2047) r = $urandom_range(0, 2047);
    if (c < 0 || c > 2047) c = $urandom_range(0, 2047);
    send_query(11'(r), 11'(c));
  endtask

  task automatic run_items(int n);
    int rows, cols;
    repeat (n) begin
      rows = sb.eff_rows();
      cols = sb.eff_cols();
      if ($urandom_range(0, 99) < 35) begin
        if ($urandom_range(0, 4) == 0 || rows == 0 || cols == 0)
          send(0, 11'($urandom_range(0, 2047)), 11'($urandom_range(0, 2047)),
               24'($urandom_range(0, 24'hffffff)));
        else
          send(0, 11'($urandom_range(0, rows - 1)), 11'($urandom_range(0, cols - 1)),
               24'($urandom_range(0, 24'hffffff)));
      end else begin
        random_query();
      end
    end
  endtask

  initial begin
    real ang;
    int size;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1;

    // reset settings: identity over the full store
    send(0, 0, 0, 24'h000000);
    send(0, 0, 1, 24'hffffff);
    send(0, 1, 0, 24'hff00ff);
    send(0, 1, 1, 24'h00ff00);
    send(0, 2047, 2047, 24'h123456);
    send(0, 1024, 0, 24'habcdef);
    send(0, 0, 1024, 24'habcdef);
    send_query(0, 0);
    send_query(1023, 1023);
    send_query(0, 1023);
    send_query(2047, 5);
    send_query(1024, 1024);

    configure(16384, 0, 0, 0, 1, 1);
    send_query(0, 0);
    send_query(0, 1);
    run_items(30);
    configure(-16384, 0, -2048, -2048, 16, 16);
    run_items(50);
    configure(0, 16384, 0, -2048, 1024, 1024);
    run_items(30);
    configure(0, -16384, 2048, 0, 20, 12);
    run_items(50);
    configure(16384, 0, 0, 0, 0, 2047);
    run_items(20);
    configure(16384, 0, 1, 3, 2047, 2047);
    run_items(25);
    configure(32767, -32768, 4095, 4096, 9, 9);
    run_items(30);
    repeat (10) begin
      ang = ($urandom_range(0, 3599) / 10.0) * 3.14159265358979 / 180.0;
      size = $urandom_range(0, 7) == 0 ? $urandom_range(100, 1024) : $urandom_range(1, 40);
      configure($rtoi($cos(ang) * 16384.0), $rtoi($sin(ang) * 16384.0),
                -$urandom_range(0, 48), -$urandom_range(0, 48),
                size, $urandom_range(1, 40));
      run_items(30);
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule
